>>> rtl/core/vertex_set_bounding_box_normalizer_macros.svh
// Assertion macros used by the normalizer top module.
// The modules that use them provide clk and arst_n.
`ifndef VERTEX_SET_BOUNDING_BOX_NORMALIZER_MACROS_SVH
`define VERTEX_SET_BOUNDING_BOX_NORMALIZER_MACROS_SVH
`ifndef SYNTHESIS
`define VSBN_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vsbn: same-cycle check failed");
`define VSBN_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vsbn: next-cycle check failed");
`else
`define VSBN_ASSERT_SAME(name, ante, cons)
`define VSBN_ASSERT_NEXT(name, ante, cons)
`endif
`endif

>>> rtl/core/vsbn_pkg.sv
`default_nettype none
package vsbn_pkg;
	localparam int AXES    = 3;
	localparam int COORD_W = 32;
	localparam int NORM_W  = 18;
	localparam int INDEX_W = 6;
	localparam int FRAC_W  = 16;
	localparam int QUO_W   = FRAC_W + 1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [NORM_W-1:0]  norm_t;
	typedef logic [COORD_W-1:0]        span_t;
	typedef logic [QUO_W-1:0]          quo_t;
	typedef logic [INDEX_W-1:0]        index_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam norm_t  NORM_ONE  = norm_t'(1 << FRAC_W);
endpackage
`default_nettype wire

>>> rtl/core/vsbn_if.sv
`default_nettype none
interface vsbn_vtx_if;
	logic             valid;
	logic             ready;
	vsbn_pkg::coord_t coord_x;
	vsbn_pkg::coord_t coord_y;
	vsbn_pkg::coord_t coord_z;
	logic             final_vertex;

	modport source (output valid, coord_x, coord_y, coord_z, final_vertex, input ready);
	modport sink (input valid, coord_x, coord_y, coord_z, final_vertex, output ready);
endinterface

interface vsbn_res_if;
	logic             valid;
	logic             ready;
	vsbn_pkg::norm_t  norm_x;
	vsbn_pkg::norm_t  norm_y;
	vsbn_pkg::norm_t  norm_z;
	vsbn_pkg::index_t vertex_index;
	logic             end_of_set;
	logic             degenerate;
	logic             overflowed;

	modport source (output valid, norm_x, norm_y, norm_z, vertex_index, end_of_set,
		degenerate, overflowed, input ready);
	modport sink (input valid, norm_x, norm_y, norm_z, vertex_index, end_of_set,
		degenerate, overflowed, output ready);
endinterface
`default_nettype wire

>>> rtl/core/vsbn_ram.sv
`default_nettype none
module vsbn_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/vsbn_div.sv
`default_nettype none
// Bit-serial restoring divider: quo = floor(mag * 2^FRAC_W / span), with mag <= span.
module vsbn_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire vsbn_pkg::span_t   mag,
	input  wire vsbn_pkg::span_t   span,
	output logic                   busy,
	output vsbn_pkg::quo_t         quo
);
	localparam int STEP_W = $clog2(vsbn_pkg::FRAC_W + 1);

	vsbn_pkg::span_t              rem_q;
	vsbn_pkg::quo_t               quo_q;
	logic [STEP_W-1:0]            step_q;
	logic                         busy_q;
	logic [vsbn_pkg::COORD_W:0]   trial;
	logic                         take;

	assign trial = {rem_q, 1'b0};
	assign take  = trial >= {1'b0, span};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(vsbn_pkg::FRAC_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// integer bit: only set when the vertex sits on the widest face
			rem_q <= (mag >= span) ? mag - span : mag;
			quo_q <= vsbn_pkg::quo_t'(mag >= span);
		end else if (busy_q) begin
			rem_q <= take ? vsbn_pkg::span_t'(trial - {1'b0, span})
				: trial[vsbn_pkg::COORD_W-1:0];
			quo_q <= {quo_q[vsbn_pkg::QUO_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

>>> rtl/core/vertex_set_bounding_box_normalizer.sv
`default_nettype none
// Loads signed Q16.16 vertices at one beat per cycle (ready only in the load state) into a
// store of MAX_VERTICES entries while tracking the per-axis box; the beat with final_vertex
// set closes the set. After a setup state that latches the span, each stored vertex is read
// back and divided on three bit-serial dividers of 16 fraction steps (skipped if degenerate);
// the next vertex is read only once the previous result has entered the output register.
// The last result may wait at the output while loading of the next set begins. Vertices that
// arrive with the store full are dropped and reported as overflowed. The store needs no
// clearing pass after reset: only entries written in the current set are read.
`include "vertex_set_bounding_box_normalizer_macros.svh"
module vertex_set_bounding_box_normalizer #(
	parameter int MAX_VERTICES = 64
) (
	input wire logic  clk,
	input wire logic  arst_n,
	vsbn_vtx_if.sink  vertices,
	vsbn_res_if.source results
);
	localparam int ADDR_W = $clog2(MAX_VERTICES);
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int CW     = vsbn_pkg::COORD_W;
	localparam int WORD_W = vsbn_pkg::AXES * CW;

	localparam logic [2:0] S_LOAD = 3'd0;
	localparam logic [2:0] S_SPAN = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_NUM  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;

	logic [2:0]             state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [ADDR_W-1:0]      idx_q;
	logic                   drop_q;
	vsbn_pkg::coord_t       lo_q [vsbn_pkg::AXES];
	vsbn_pkg::coord_t       hi_q [vsbn_pkg::AXES];
	logic signed [CW+1:0]   sum_q [vsbn_pkg::AXES];
	logic                   neg_q [vsbn_pkg::AXES];
	vsbn_pkg::span_t        span_q;
	logic                   degen_q;

	vsbn_pkg::coord_t       in_coord [vsbn_pkg::AXES];
	vsbn_pkg::coord_t       rd_coord [vsbn_pkg::AXES];
	vsbn_pkg::span_t        ext [vsbn_pkg::AXES];
	vsbn_pkg::span_t        span_max;
	logic signed [CW+2:0]   num [vsbn_pkg::AXES];
	logic signed [CW+2:0]   num_neg [vsbn_pkg::AXES];
	vsbn_pkg::span_t        mag [vsbn_pkg::AXES];
	vsbn_pkg::quo_t         quo [vsbn_pkg::AXES];
	vsbn_pkg::norm_t        norm [vsbn_pkg::AXES];
	logic [vsbn_pkg::AXES-1:0] busy;
	logic [WORD_W-1:0]      rd_word;

	logic in_fire, in_store, full, div_start, out_load, out_last, set_done, out_fire;

	logic              out_valid_q;
	vsbn_pkg::norm_t   out_x_q, out_y_q, out_z_q;
	vsbn_pkg::index_t  out_index_q;
	logic              out_end_q, out_degen_q, out_ovf_q;

	assign in_coord[0] = vertices.coord_x;
	assign in_coord[1] = vertices.coord_y;
	assign in_coord[2] = vertices.coord_z;

	assign vertices.ready = (state_q == S_LOAD);
	assign in_fire   = vertices.valid && vertices.ready;
	assign full      = (cnt_q == CNT_W'(MAX_VERTICES));
	assign in_store  = in_fire && !full;
	assign div_start = (state_q == S_NUM) && !degen_q;
	assign out_fire  = out_valid_q && results.ready;
	assign out_load  = (state_q == S_DIV) && (busy == '0) && (!out_valid_q || results.ready);
	assign out_last  = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
	assign set_done  = out_load && out_last;

	vsbn_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_VERTICES)
	) u_store (
		.clk   (clk),
		.we    (in_store),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata ({in_coord[2], in_coord[1], in_coord[0]}),
		.re    (state_q == S_READ),
		.raddr (idx_q),
		.rdata (rd_word)
	);

	always_comb begin
		span_max = '0;
		for (int a = 0; a < vsbn_pkg::AXES; a++) begin
			rd_coord[a] = rd_word[a*CW +: CW];
			ext[a]      = hi_q[a] - lo_q[a];
			if (ext[a] > span_max) begin
				span_max = ext[a];
			end
			// 2v - (hi + lo); its magnitude never exceeds the extent
			num[a]     = {{2{rd_coord[a][CW-1]}}, rd_coord[a], 1'b0} - {sum_q[a][CW+1], sum_q[a]};
			num_neg[a] = -num[a];
			mag[a]     = num[a][CW+2] ? num_neg[a][CW-1:0] : num[a][CW-1:0];
			if (degen_q) begin
				norm[a] = '0;
			end else if (neg_q[a]) begin
				norm[a] = -vsbn_pkg::norm_t'(quo[a]);
			end else begin
				norm[a] = vsbn_pkg::norm_t'(quo[a]);
			end
		end
	end

	for (genvar a = 0; a < vsbn_pkg::AXES; a++) begin : g_lane
		vsbn_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start),
			.mag    (mag[a]),
			.span   (span_q),
			.busy   (busy[a]),
			.quo    (quo[a])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			idx_q   <= '0;
			drop_q  <= 1'b0;
			for (int a = 0; a < vsbn_pkg::AXES; a++) begin
				lo_q[a] <= vsbn_pkg::COORD_MAX;
				hi_q[a] <= vsbn_pkg::COORD_MIN;
			end
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_fire) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
							for (int a = 0; a < vsbn_pkg::AXES; a++) begin
								if (in_coord[a] < lo_q[a]) begin
									lo_q[a] <= in_coord[a];
								end
								if (in_coord[a] > hi_q[a]) begin
									hi_q[a] <= in_coord[a];
								end
							end
						end
						if (vertices.final_vertex) begin
							state_q <= S_SPAN;
						end
					end
				end
				S_SPAN: begin
					idx_q   <= '0;
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_NUM;
				end
				S_NUM: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (out_load) begin
						if (out_last) begin
							// start a fresh set while the last result may still wait
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							state_q <= S_LOAD;
							for (int a = 0; a < vsbn_pkg::AXES; a++) begin
								lo_q[a] <= vsbn_pkg::COORD_MAX;
								hi_q[a] <= vsbn_pkg::COORD_MIN;
							end
						end else begin
							idx_q   <= idx_q + ADDR_W'(1);
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SPAN) begin
			span_q  <= span_max;
			degen_q <= (span_max == '0);
			for (int a = 0; a < vsbn_pkg::AXES; a++) begin
				sum_q[a] <= {{2{hi_q[a][CW-1]}}, hi_q[a]} + {{2{lo_q[a][CW-1]}}, lo_q[a]};
			end
		end
		if (state_q == S_NUM) begin
			for (int a = 0; a < vsbn_pkg::AXES; a++) begin
				neg_q[a] <= num[a][CW+2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q     <= norm[0];
			out_y_q     <= norm[1];
			out_z_q     <= norm[2];
			out_index_q <= vsbn_pkg::index_t'(idx_q);
			out_end_q   <= out_last;
			out_degen_q <= degen_q;
			out_ovf_q   <= drop_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.norm_x       = out_x_q;
	assign results.norm_y       = out_y_q;
	assign results.norm_z       = out_z_q;
	assign results.vertex_index = out_index_q;
	assign results.end_of_set   = out_end_q;
	assign results.degenerate   = out_degen_q;
	assign results.overflowed   = out_ovf_q;

	`VSBN_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_VERTICES))
	`VSBN_ASSERT_NEXT(a_set_cleared, set_done, state_q == S_LOAD && cnt_q == '0 && !drop_q)
	`VSBN_ASSERT_SAME(a_div_in_state, busy != '0, state_q == S_DIV)
	`VSBN_ASSERT_SAME(a_norm_range, results.valid,
		results.norm_x <= vsbn_pkg::NORM_ONE && results.norm_x >= -vsbn_pkg::NORM_ONE &&
		results.norm_y <= vsbn_pkg::NORM_ONE && results.norm_y >= -vsbn_pkg::NORM_ONE &&
		results.norm_z <= vsbn_pkg::NORM_ONE && results.norm_z >= -vsbn_pkg::NORM_ONE)
	`VSBN_ASSERT_SAME(a_degen_zero, results.valid && results.degenerate,
		results.norm_x == '0 && results.norm_y == '0 && results.norm_z == '0)
endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	localparam int DEPTH = 64;

	typedef enum int {SHAPE_POINT, SHAPE_LINE, SHAPE_CLUSTER, SHAPE_SCATTER} set_shape_t;
	typedef enum int {CK_WIDE, CK_NEAR, CK_EDGE} coord_kind_t;

	typedef struct {
		vsbn_pkg::coord_t x;
		vsbn_pkg::coord_t y;
		vsbn_pkg::coord_t z;
		logic   last;
		logic   hold;
		int     gap;
	} vtx_beat_t;

	typedef struct {
		vsbn_pkg::norm_t  nx;
		vsbn_pkg::norm_t  ny;
		vsbn_pkg::norm_t  nz;
		vsbn_pkg::index_t idx;
		logic   eos;
		logic   degen;
		logic   ovf;
	} norm_res_t;

	logic clk;
	logic arst_n;

	vsbn_vtx_if vtx_ch();
	vsbn_res_if res_ch();

	vertex_set_bounding_box_normalizer #(
		.MAX_VERTICES(DEPTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.vertices(vtx_ch),
		.results (res_ch)
	);

	vtx_beat_t vtx_pending[$];
	norm_res_t norm_expected[$];

	// box predictor state
	vsbn_pkg::coord_t set_pts[DEPTH][vsbn_pkg::AXES];
	vsbn_pkg::coord_t box_lo[vsbn_pkg::AXES];
	vsbn_pkg::coord_t box_hi[vsbn_pkg::AXES];
	int     set_count;
	logic   set_dropped;

	int   fail_count = 0;
	int   res_count = 0;
	int   gap_left = 0;
	int   stall_left = 0;
	bit   vtx_fire = 0;
	bit   res_fire = 0;
	bit   tx_calm = 0;
	int   random_items = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic void clear_box();
		for (int a = 0; a < vsbn_pkg::AXES; a++) begin
			box_lo[a] = vsbn_pkg::COORD_MAX;
			box_hi[a] = vsbn_pkg::COORD_MIN;
		end
		set_count = 0;
		set_dropped = 1'b0;
	endfunction

	function automatic vsbn_pkg::norm_t scale_coord(vsbn_pkg::coord_t v, vsbn_pkg::coord_t lo,
			vsbn_pkg::coord_t hi, longint span);
		longint num;
		longint unsigned mag;
		longint unsigned q;
		longint r;
		num = 2 * longint'(v) - longint'(hi) - longint'(lo);
		mag = longint'(num < 0 ? -num : num) << vsbn_pkg::FRAC_W;
		q = mag / longint'(span);
		r = (num < 0) ? -longint'(q) : longint'(q);
		return vsbn_pkg::norm_t'(r);
	endfunction

	task automatic absorb_vertex(vsbn_pkg::coord_t x, vsbn_pkg::coord_t y, vsbn_pkg::coord_t z,
			logic last);
		vsbn_pkg::coord_t p[vsbn_pkg::AXES];
		longint span;
		longint e;
		norm_res_t r;
		p = '{x, y, z};
		if (set_count < DEPTH) begin
			for (int a = 0; a < vsbn_pkg::AXES; a++) begin
				set_pts[set_count][a] = p[a];
				if (p[a] < box_lo[a]) box_lo[a] = p[a];
				if (p[a] > box_hi[a]) box_hi[a] = p[a];
			end
			set_count++;
		end else begin
			set_dropped = 1'b1;
		end
		if (last) begin
			span = 0;
			for (int a = 0; a < vsbn_pkg::AXES; a++) begin
				e = longint'(box_hi[a]) - longint'(box_lo[a]);
				if (e > span) span = e;
			end
			for (int k = 0; k < set_count; k++) begin
				if (span == 0) begin
					r.nx = '0;
					r.ny = '0;
					r.nz = '0;
				end else begin
					r.nx = scale_coord(set_pts[k][0], box_lo[0], box_hi[0], span);
					r.ny = scale_coord(set_pts[k][1], box_lo[1], box_hi[1], span);
					r.nz = scale_coord(set_pts[k][2], box_lo[2], box_hi[2], span);
				end
				r.idx = vsbn_pkg::index_t'(k);
				r.eos = (k == set_count - 1);
				r.degen = (span == 0);
				r.ovf = set_dropped;
				norm_expected.push_back(r);
			end
			clear_box();
		end
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// monitor: check result beats, then feed accepted vertex beats to the predictor
	always @(posedge clk) begin : monitor
		norm_res_t want;
		vtx_fire = (vtx_ch.valid && vtx_ch.ready) === 1'b1;
		res_fire = (res_ch.valid && res_ch.ready) === 1'b1;
		if (arst_n) begin
			if (res_fire) begin
				res_count++;
				if (norm_expected.size() == 0) begin
					$error("result beat with no expectation: vertex_index %0d",
						res_ch.vertex_index);
					fail_count++;
				end else begin
					want = norm_expected.pop_front();
					check_field("norm_x", want.nx, res_ch.norm_x);
					check_field("norm_y", want.ny, res_ch.norm_y);
					check_field("norm_z", want.nz, res_ch.norm_z);
					check_field("vertex_index", want.idx, res_ch.vertex_index);
					check_field("end_of_set", want.eos, res_ch.end_of_set);
					check_field("degenerate", want.degen, res_ch.degenerate);
					check_field("overflowed", want.ovf, res_ch.overflowed);
				end
			end
			if (vtx_fire)
				absorb_vertex(vtx_ch.coord_x, vtx_ch.coord_y, vtx_ch.coord_z,
					vtx_ch.final_vertex);
		end
	end

	// vertex driver
	always @(negedge clk) begin : driver
		vtx_beat_t b;
		if (arst_n) begin
			if (!vtx_ch.valid || vtx_fire) begin
				if (vtx_fire)
					gap_left = (vtx_pending.size() != 0) ? vtx_pending[0].gap : 0;
				if (gap_left > 0) begin
					gap_left--;
					vtx_ch.valid <= 1'b0;
				end else if (vtx_pending.size() != 0 &&
						!(vtx_pending[0].hold && norm_expected.size() != 0)) begin
					b = vtx_pending.pop_front();
					vtx_ch.coord_x <= b.x;
					vtx_ch.coord_y <= b.y;
					vtx_ch.coord_z <= b.z;
					vtx_ch.final_vertex <= b.last;
					vtx_ch.valid <= 1'b1;
				end else begin
					vtx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result receiver: stall per beat, with calm stretches
	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (res_fire)
				stall_left = ((res_count / 30) % 3 == 2) ? 0 : $urandom_range(0, 19);
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	function automatic vsbn_pkg::coord_t rand_coord(coord_kind_t kind);
		vsbn_pkg::coord_t c;
		case (kind)
			CK_WIDE: c = vsbn_pkg::coord_t'($urandom);
			CK_NEAR: c = vsbn_pkg::coord_t'(int'($urandom_range(0, 200000)) - 100000);
			default: begin
				case ($urandom_range(0, 4))
					0: c = vsbn_pkg::COORD_MIN;
					1: c = vsbn_pkg::COORD_MAX;
					2: c = '0;
					3: c = -1;
					default: c = 1;
				endcase
			end
		endcase
		return c;
	endfunction

	function automatic coord_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 9);
		return (r < 5) ? CK_WIDE : (r < 8) ? CK_NEAR : CK_EDGE;
	endfunction

	task automatic add_beat(vsbn_pkg::coord_t x, vsbn_pkg::coord_t y, vsbn_pkg::coord_t z,
			logic last, logic hold);
		vtx_beat_t b;
		b.x = x;
		b.y = y;
		b.z = z;
		b.last = last;
		b.hold = hold;
		b.gap = tx_calm ? 0 : $urandom_range(0, 19);
		vtx_pending.push_back(b);
	endtask

	task automatic add_set(int n, set_shape_t shape, logic hold);
		vsbn_pkg::coord_t base[vsbn_pkg::AXES];
		vsbn_pkg::coord_t p[vsbn_pkg::AXES];
		for (int a = 0; a < vsbn_pkg::AXES; a++)
			base[a] = rand_coord(pick_kind());
		tx_calm = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < n; i++) begin
			p = base;
			case (shape)
				SHAPE_POINT: ;
				SHAPE_LINE: p[$urandom_range(0, vsbn_pkg::AXES - 1)] = rand_coord(pick_kind());
				SHAPE_CLUSTER: begin
					for (int a = 0; a < vsbn_pkg::AXES; a++)
						p[a] = base[a] +
							vsbn_pkg::coord_t'(int'($urandom_range(0, 65536)) - 32768);
				end
				default: begin
					for (int a = 0; a < vsbn_pkg::AXES; a++)
						p[a] = rand_coord(pick_kind());
				end
			endcase
			add_beat(p[0], p[1], p[2], i == n - 1, hold && i == 0);
		end
		random_items += n;
	endtask

	initial begin : main
		set_shape_t shape;
		int r;
		arst_n = 1'b0;
		vtx_ch.valid = 1'b0;
		vtx_ch.coord_x = '0;
		vtx_ch.coord_y = '0;
		vtx_ch.coord_z = '0;
		vtx_ch.final_vertex = 1'b0;
		res_ch.ready = 1'b0;
		clear_box();

		// single vertex set: zero extent
		add_beat('0, '0, '0, 1'b1, 1'b0);
		// full-range corners on two axes
		add_beat(vsbn_pkg::COORD_MIN, vsbn_pkg::COORD_MAX, '0, 1'b0, 1'b0);
		add_beat(vsbn_pkg::COORD_MAX, vsbn_pkg::COORD_MIN, '0, 1'b1, 1'b0);
		// hold until the previous sets are out
		add_beat(vsbn_pkg::COORD_MAX, vsbn_pkg::COORD_MAX, vsbn_pkg::COORD_MAX, 1'b0, 1'b1);
		add_beat(vsbn_pkg::COORD_MIN, vsbn_pkg::COORD_MIN, vsbn_pkg::COORD_MIN, 1'b0, 1'b0);
		add_beat('0, '0, '0, 1'b0, 1'b0);
		add_beat(-1, 1, -1, 1'b1, 1'b0);
		// repeated point: degenerate
		add_beat(-(5 << 16), 7, vsbn_pkg::COORD_MIN, 1'b0, 1'b0);
		add_beat(-(5 << 16), 7, vsbn_pkg::COORD_MIN, 1'b0, 1'b0);
		add_beat(-(5 << 16), 7, vsbn_pkg::COORD_MIN, 1'b1, 1'b0);
		// one axis spans, extent 4: results of both signs
		add_beat(1, 0, 0, 1'b0, 1'b0);
		add_beat(-1, 0, 0, 1'b0, 1'b0);
		add_beat(3, 0, 0, 1'b0, 1'b0);
		add_beat(2, 0, 0, 1'b1, 1'b0);
		// z dominates the extent
		add_beat(0, 0, -3, 1'b0, 1'b0);
		add_beat(1, 0, 4, 1'b0, 1'b0);
		add_beat(-1, 2, 0, 1'b1, 1'b0);

		random_items = 0;
		while (random_items < 300) begin
			r = $urandom_range(0, 9);
			shape = (r == 0) ? SHAPE_POINT : (r == 1) ? SHAPE_LINE :
				(r < 6) ? SHAPE_CLUSTER : SHAPE_SCATTER;
			if (random_items > 40 && random_items < 50)
				add_set(DEPTH, SHAPE_SCATTER, 1'b0);
			else if (random_items > 150 && random_items < 160)
				add_set(DEPTH + 3, shape, $urandom_range(0, 1) == 1);
			else
				add_set(($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) :
					$urandom_range(1, 8), shape, $urandom_range(0, 7) == 0);
		end

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (vtx_pending.size() != 0 || vtx_ch.valid) @(negedge clk);
		while (norm_expected.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0 && norm_expected.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
